// ===== rtl/scc_pkg.sv =====
package scc_pkg;

	// angle units: 1/64 degree
	localparam logic signed [16:0] ANG_CIRCLE  = 17'sd23040;
	localparam logic signed [16:0] ANG_HALF    = 17'sd11520;
	localparam logic signed [16:0] ANG_QUARTER = 17'sd5760;

	// CORDIC gain 0.607252935 in Q2.30
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
	localparam int CORDIC_MAX_STEPS = 24;

	// atan(2^-i) in units of 2^-24 degree
	localparam logic [31:0] ATAN_TAB [CORDIC_MAX_STEPS] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000935,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	// register indexes
	localparam logic [1:0] REG_IGNORE_SLOPE  = 2'd0;
	localparam logic [1:0] REG_SHADOW_ENABLE = 2'd1;
	localparam logic [1:0] REG_MIN_ELEVATION = 2'd2;

	localparam logic [12:0] MIN_ELEVATION_RST = 13'd192;

	typedef struct packed {
		logic        ignore_slope;
		logic        shadow_enable;
		logic [12:0] min_elevation;
	} cfg_t;

	// per-face fields that ride alongside the CORDIC
	typedef struct packed {
		logic signed [13:0] elevation;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [14:0]        direct_in;
		logic [14:0]        diffuse_in;
		logic               shadowed;
	} side_t;

endpackage

// ===== rtl/slope_shortwave_correction_top.sv =====
// Slope incidence-angle correction of shortwave radiation, one mesh face per item.
//
// Input stream (s_*): one face per item; sun azimuth/elevation, face normal,
// direct and diffuse radiation in tdata, the remote-terrain shadow flag in tuser.
// Output stream (m_*): incidence cosine, corrected direct and total radiation.
// Config channel (cfg_*): always ready; index 0 ignore_slope, 1 shadow_enable,
// 2 min_elevation. Write only while the pipeline is empty.
//
// Throughput: one item per cycle while the output is not stalled. Registers from
// acceptance to m_tvalid: angle fold, CORDIC_STAGES rotation stages, sign fix,
// then four stages: sun vector multiply, normal products, sum/clamp,
// radiation scale into the output register.
// The whole pipeline advances on one enable: when m_tready is low with a
// result held, every stage freezes and s_tready drops; an empty output
// register keeps the pipeline moving regardless of m_tready.
// Reset clears the valid bits and returns the registers to ignore_slope = 0,
// shadow_enable = 0, min_elevation = 192 (3 degrees).
module slope_shortwave_correction_top
	import scc_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [14:0] azimuth, [28:15] elevation, [44:29] normal_x, [60:45] normal_y,
	// [76:61] normal_z, [91:77] direct_in, [106:92] diffuse_in, rest zero
	input  logic [111:0] s_tdata,
	// [0] shadowed
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [14:0] incidence_cos, [29:15] direct_out, [45:30] total_out, rest zero
	output logic [47:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [12:0]  cfg_data
);

	localparam int LAT = CORDIC_STAGES + 2;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ignore_slope  <= 1'b0;
			cfg_q.shadow_enable <= 1'b0;
			cfg_q.min_elevation <= MIN_ELEVATION_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IGNORE_SLOPE:  cfg_q.ignore_slope  <= cfg_data[0];
				REG_SHADOW_ENABLE: cfg_q.shadow_enable <= cfg_data[0];
				REG_MIN_ELEVATION: cfg_q.min_elevation <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	side_t side_in;
	always_comb begin
		side_in.elevation  = s_tdata[28:15];
		side_in.normal_x   = s_tdata[44:29];
		side_in.normal_y   = s_tdata[60:45];
		side_in.normal_z   = s_tdata[76:61];
		side_in.direct_in  = s_tdata[91:77];
		side_in.diffuse_in = s_tdata[106:92];
		side_in.shadowed   = s_tuser;
	end

	logic signed [31:0] sa, ca, se, ce;

	scc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_az (
		.clk   (clk),
		.en    (en),
		.angle ({1'b0, s_tdata[14:0]}),
		.sin_v (sa),
		.cos_v (ca)
	);

	scc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_el (
		.clk   (clk),
		.en    (en),
		.angle ({{2{s_tdata[28]}}, s_tdata[28:15]}),
		.sin_v (se),
		.cos_v (ce)
	);

	// side fields and valid bits matched to the CORDIC latency
	side_t side_d [LAT];
	logic  [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_in;
			for (int i = 1; i < LAT; i++)
				side_d[i] <= side_d[i-1];
		end
	end

	logic [14:0] cos_o, dout_o;
	logic [15:0] tot_o;

	scc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_q[LAT-1]),
		.sa        (sa),
		.ca        (ca),
		.se        (se),
		.ce        (ce),
		.side      (side_d[LAT-1]),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.cos_q     (cos_o),
		.dout_q    (dout_o),
		.tot_q     (tot_o)
	);

	assign m_tdata = {2'b00, tot_o, dout_o, cos_o};

endmodule

// ===== rtl/scc_cordic.sv =====
module scc_cordic
	import scc_pkg::*;
#(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] angle,
	output logic signed [31:0] sin_v,
	output logic signed [31:0] cos_v
);

	logic signed [16:0] a0, a1, a2, d;
	logic               negf;
	logic signed [35:0] z0;

	// wrap into [-180,180) then fold into [-90,90]
	always_comb begin
		a0 = {angle[15], angle};
		a1 = (a0 >= ANG_CIRCLE) ? a0 - ANG_CIRCLE : a0;
		a2 = (a1 >= ANG_HALF) ? a1 - ANG_CIRCLE : a1;
		negf = 1'b0;
		d = a2;
		if (a2 > ANG_QUARTER) begin
			d = a2 - ANG_HALF;
			negf = 1'b1;
		end else if (a2 < -ANG_QUARTER) begin
			d = a2 + ANG_HALF;
			negf = 1'b1;
		end
		z0 = $signed({d[16], d, 18'd0});
	end

	logic signed [33:0] x_s [STAGES+1];
	logic signed [33:0] y_s [STAGES+1];
	logic signed [35:0] z_s [STAGES+1];
	logic               neg_s [STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= CORDIC_GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= z0;
			neg_s[0] <= negf;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_step
		localparam logic signed [35:0] ATN = $signed({4'd0, ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][35]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATN;
				end
			end
		end
	end

	logic signed [33:0] xn, yn;
	assign xn = neg_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
	assign yn = neg_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			sin_v <= yn[31:0];
			cos_v <= xn[31:0];
		end
	end

endmodule

// ===== rtl/scc_post.sv =====
module scc_post
	import scc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [31:0] sa,
	input  logic signed [31:0] ca,
	input  logic signed [31:0] se,
	input  logic signed [31:0] ce,
	input  side_t              side,
	input  cfg_t               cfg,
	output logic               out_valid,
	output logic [14:0]        cos_q,
	output logic [14:0]        dout_q,
	output logic [15:0]        tot_q
);

	logic v_s1, v_s2, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	// stage 1: sun x/y, effective normal
	logic signed [63:0] pa, pb;
	assign pa = ce * sa;
	assign pb = ce * ca;

	logic signed [33:0] sx_s1, sy_s1;
	logic signed [31:0] sz_s1;
	logic signed [16:0] nx_s1, ny_s1, nz_s1;
	side_t              sd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= pa[63:30];
			sy_s1 <= pb[63:30];
			sz_s1 <= se;
			sd_s1 <= side;
			if (cfg.ignore_slope) begin
				nx_s1 <= '0;
				ny_s1 <= '0;
				nz_s1 <= 17'sd32768;
			end else begin
				nx_s1 <= {side.normal_x[15], side.normal_x};
				ny_s1 <= {side.normal_y[15], side.normal_y};
				nz_s1 <= {side.normal_z[15], side.normal_z};
			end
		end
	end

	// stage 2: products
	logic signed [50:0] px_s2, py_s2;
	logic signed [48:0] pz_s2;
	side_t              sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= sx_s1 * nx_s1;
			py_s2 <= sy_s1 * ny_s1;
			pz_s2 <= sz_s1 * nz_s1;
			sd_s2 <= sd_s1;
		end
	end

	// stage 3: sum, round, clamp, gates
	logic signed [52:0] dot;
	logic signed [22:0] q;
	logic        [14:0] cq;

	always_comb begin
		dot = 53'(px_s2) + 53'(py_s2) + 53'(pz_s2) + 53'sd536870912;
		q   = dot[52:30];
		if (q < 0 || sd_s2.elevation < $signed({1'b0, cfg.min_elevation}))
			cq = '0;
		else if (q > 23'sd32767)
			cq = 15'd32767;
		else
			cq = q[14:0];
	end

	logic [14:0] cq_s3, ceff_s3, dir_s3, dif_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cq_s3   <= cq;
			ceff_s3 <= (cfg.shadow_enable && sd_s2.shadowed) ? 15'd0 : cq;
			dir_s3  <= sd_s2.direct_in;
			dif_s3  <= sd_s2.diffuse_in;
		end
	end

	// stage 4: radiation, output register
	logic [30:0] rp;
	logic [15:0] rs;
	logic [14:0] dout;
	logic [16:0] tsum;

	always_comb begin
		rp   = 31'(ceff_s3) * 31'(dir_s3) + 31'd16384;
		rs   = rp[30:15];
		dout = (rs > 16'd32767) ? 15'd32767 : rs[14:0];
		tsum = 17'(dout) + 17'(dif_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q  <= cq_s3;
			dout_q <= dout;
			tot_q  <= (tsum > 17'd65535) ? 16'hFFFF : tsum[15:0];
		end
	end

endmodule

// ===== tb/slope_shortwave_correction_top_tb.sv =====
`timescale 1ns / 1ps

module slope_shortwave_correction_top_tb;
	import scc_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 6;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [14:0] azimuth;
		logic signed [13:0] elevation;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [14:0] direct_in;
		logic [14:0] diffuse_in;
		logic shadowed;
	} face_t;

	typedef struct {
		logic [14:0] incidence_cos;
		logic [14:0] direct_out;
		logic [15:0] total_out;
	} irradiance_t;

	// settings mirrored from the configuration writes
	logic cur_ignore_slope;
	logic cur_shadow_enable;
	logic [12:0] cur_min_elevation;

	// sin/cos in Q2.30 from an angle in 1/64 degree
	function automatic void sun_sincos(input longint ang, output longint s, output longint c);
		longint d, x, y, z, nx;
		bit flip;
		d = ang % 23040;
		if (d < 0) d += 23040;
		if (d >= 11520) d -= 23040;
		flip = 0;
		if (d > 5760) begin
			d -= 11520;
			flip = 1;
		end else if (d < -5760) begin
			d += 11520;
			flip = 1;
		end
		x = 652032875;
		y = 0;
		z = d * 262144;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endfunction

	function automatic irradiance_t correct_face(input face_t f);
		irradiance_t r;
		longint sa, ca, se, ce, sx, sy, nx, ny, nz, dot, cq, ceff, dout, tot;
		sun_sincos(longint'(f.azimuth), sa, ca);
		sun_sincos(longint'(f.elevation), se, ce);
		sx = (ce * sa) >>> 30;
		sy = (ce * ca) >>> 30;
		nx = longint'(f.normal_x);
		ny = longint'(f.normal_y);
		nz = longint'(f.normal_z);
		if (cur_ignore_slope) begin
			nx = 0;
			ny = 0;
			nz = 32768;
		end
		dot = sx * nx + sy * ny + se * nz;
		cq = (dot + (longint'(1) << 29)) >>> 30;
		if (cq > 32767) cq = 32767;
		if (cq < -32768) cq = -32768;
		if (cq < 0 || longint'(f.elevation) < longint'(cur_min_elevation)) cq = 0;
		ceff = (cur_shadow_enable && f.shadowed) ? 0 : cq;
		dout = (ceff * longint'(f.direct_in) + 16384) >>> 15;
		if (dout > 32767) dout = 32767;
		tot = dout + longint'(f.diffuse_in);
		if (tot > 65535) tot = 65535;
		r.incidence_cos = cq[14:0];
		r.direct_out = dout[14:0];
		r.total_out = tot[15:0];
		return r;
	endfunction

	class irradiance_board;
		irradiance_t pending[$];
		int mismatches;

		function void note_face(face_t f);
			pending.push_back(correct_face(f));
		endfunction

		function void check_result(logic [47:0] data);
			irradiance_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", data);
				return;
			end
			exp_r = pending.pop_front();
			if (data[14:0] !== exp_r.incidence_cos || data[29:15] !== exp_r.direct_out
					|| data[45:30] !== exp_r.total_out || data[47:46] !== 2'b00) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: cos %0d/%0d direct %0d/%0d total %0d/%0d",
						exp_r.incidence_cos, data[14:0], exp_r.direct_out, data[29:15],
						exp_r.total_out, data[45:30]);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [111:0] s_tdata;	// azimuth, elevation, normal x/y/z, direct_in, diffuse_in
	logic s_tuser;	// shadowed
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;	// incidence_cos, direct_out, total_out
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [12:0] cfg_data;

	slope_shortwave_correction_top #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	irradiance_board board;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	bit timed_out;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls on m_tready, check each accepted item
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IGNORE_SLOPE: cur_ignore_slope = val[0];
			REG_SHADOW_ENABLE: cur_shadow_enable = val[0];
			default: cur_min_elevation = val;
		endcase
	endtask

	task automatic set_config(input logic ign, input logic shd, input logic [12:0] minel);
		write_reg(REG_IGNORE_SLOPE, {12'd0, ign});
		write_reg(REG_SHADOW_ENABLE, {12'd0, shd});
		write_reg(REG_MIN_ELEVATION, minel);
		cfg_valid <= 0;
	endtask

	// every item yields a result; draining the queue means the pipeline is empty
	task automatic drain;
		while (board.pending.size() != 0 && quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_face(input face_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, f.diffuse_in, f.direct_in, f.normal_z, f.normal_y, f.normal_x,
			f.elevation, f.azimuth};
		s_tuser <= f.shadowed;
		do @(posedge clk); while (!s_tready);
		board.note_face(f);
	endtask

	function automatic face_t make_face(input int az, input int el, input int nx,
			input int ny, input int nz, input int dir, input int dif, input bit sh);
		face_t f;
		f.azimuth = 15'(az);
		f.elevation = 14'(el);
		f.normal_x = 16'(nx);
		f.normal_y = 16'(ny);
		f.normal_z = 16'(nz);
		f.direct_in = 15'(dir);
		f.diffuse_in = 15'(dif);
		f.shadowed = sh;
		return f;
	endfunction

	function automatic face_t random_face;
		face_t f;
		real th, ph;
		int sel;
		sel = $urandom_range(9);
		f.azimuth = 15'((sel == 0) ? $urandom_range(32767) : $urandom_range(23039));
		f.elevation = 14'((sel == 1) ? $urandom : $signed($urandom_range(11520)) - 5760);
		if (sel <= 2) begin
			// arbitrary, non-unit normals
			f.normal_x = 16'($urandom);
			f.normal_y = 16'($urandom);
			f.normal_z = 16'($urandom);
		end else begin
			th = $urandom_range(1000) * 3.14159265 / 2000.0;
			ph = $urandom_range(6283) / 1000.0;
			f.normal_x = 16'($rtoi(32767.0 * $sin(th) * $cos(ph)));
			f.normal_y = 16'($rtoi(32767.0 * $sin(th) * $sin(ph)));
			f.normal_z = 16'($rtoi(32767.0 * $cos(th)));
		end
		f.direct_in = 15'($urandom);
		f.diffuse_in = 15'($urandom);
		f.shadowed = 1'($urandom);
		return f;
	endfunction

	task automatic random_phase(input int n);
		repeat (n) send_face(random_face());
		s_tvalid <= 0;
		drain();
	endtask

	initial begin
		board = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		send_idle_pct = 38;
		recv_idle_pct = 64;
		cur_ignore_slope = 0;
		cur_shadow_enable = 0;
		cur_min_elevation = MIN_ELEVATION_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		fork
			begin
				// directed: reset settings, extremes, high sun, low sun, wraps
				send_face(make_face(0, 5760, 0, 0, 32767, 32767, 32767, 1));
				send_face(make_face(0, 5760, 0, 0, -32768, 100, 0, 0));
				send_face(make_face(23039, 191, 0, 0, 32767, 32767, 0, 0));
				send_face(make_face(5760, 192, 32767, 0, 0, 32767, 32767, 0));
				send_face(make_face(32767, -5760, -32768, -32768, -32768, 0, 32767, 1));
				send_face(make_face(11520, 2880, 0, -32768, 0, 16384, 100, 0));
				send_face(make_face(17280, -1, 32767, 32767, 32767, 32767, 32767, 1));
				send_face(make_face(0, -8192, 0, 0, 32767, 32767, 5, 0));
				send_face(make_face(100, 8191, 0, 0, 32767, 32767, 5, 0));
				send_face(make_face(2000, 4000, 32767, 32767, 32767, 32767, 32767, 0));
				s_tvalid <= 0;
				drain();
				set_config(1'b1, 1'b1, 13'd0);
				send_face(make_face(0, 5760, 32767, -32768, -32768, 32767, 32767, 1));
				send_face(make_face(5000, 5760, 0, 0, -32768, 32767, 32767, 0));
				send_face(make_face(0, 0, 32767, 0, 0, 32767, 40000, 0));
				send_face(make_face(0, -1, 0, 0, 0, 32767, 1, 1));
				send_face(make_face(777, 3000, 100, 100, 100, 1234, 4321, 0));
				s_tvalid <= 0;
				drain();
				set_config(1'b0, 1'b1, 13'd5760);
				send_face(make_face(0, 5760, 0, 0, 32767, 32767, 32767, 1));
				send_face(make_face(0, 5759, 0, 0, 32767, 32767, 32767, 0));
				s_tvalid <= 0;
				drain();

				set_config(1'b0, 1'b0, 13'd192);
				random_phase(200);
				set_config(1'b1, 1'b0, 13'd0);
				random_phase(150);
				send_idle_pct = 64;
				recv_idle_pct = 38;
				set_config(1'b0, 1'b1, 13'd8191);
				random_phase(100);
				set_config(1'b0, 1'b1, 13'd64);
				random_phase(200);
				send_idle_pct = 0;
				recv_idle_pct = 0;
				set_config(1'b1, 1'b1, 13'd5760);
				random_phase(100);
				set_config(1'b0, 1'b0, 13'd0);
				random_phase(280);
				repeat (LATENCY) @(posedge clk);
				timed_out = 0;
			end
			begin
				wait (quiet_cycles >= WATCHDOG_LIMIT);
				timed_out = 1;
			end
		join_any

		if (timed_out || board.mismatches != 0 || board.pending.size() != 0)
			$display("Testbench completed WITH ERRORS");
		else
			$display("Testbench completed without errors");
		$finish;
	end
endmodule
